[rtl/sfir_pkg.sv]
// Shared types and constants for the strided vertical FIR.
`default_nettype none
package sfir_pkg;

  localparam int TAPS_DEF      = 7;
  localparam int SLICE_MAX_DEF = 1024;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int ENTRY_W     = SAMPLE_W + 1;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int OUT_W       = 34;
  localparam int SLICE_LEN_W = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Queue depths between front and back, and ahead of the result ports.
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLICE_LENGTH = 3'd0,
    REG_COEF_0       = 3'd1,
    REG_COEF_1       = 3'd2,
    REG_COEF_2       = 3'd3,
    REG_COEF_3       = 3'd4,
    REG_COEF_4       = 3'd5,
    REG_COEF_5       = 3'd6,
    REG_COEF_6       = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic                  en;
    reg_index_t            index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage
`default_nettype wire

[rtl/strided_fir_with_missing_marks.sv]
// Top level of the strided vertical FIR with missing-sample marks.
// Throughput: one input beat per cycle while full is low; one multiply per tap and
// one line bank read per bank in every cycle set that figure.
// Reset clears control, counters and coefficients; the line banks are not
// cleared, warm-up of (TAPS-1)*slice_length beats covers their contents.
`default_nettype none
module strided_fir_with_missing_marks import sfir_pkg::*; #(
  parameter int TAPS      = TAPS_DEF,
  parameter int SLICE_MAX = SLICE_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic signed [SAMPLE_W-1:0]  sample,
  input  wire logic                        sample_missing,
  input  wire logic                        volume_start,
  output logic                             empty,
  input  wire logic                        pop,
  output logic signed [OUT_W-1:0]          filtered,
  output logic                             filtered_missing
);

  cfg_wr_t                            cfg;
  logic                               mid_push;
  logic [TAPS*ENTRY_W-1:0]            mid_wdata;
  logic [TAPS*ENTRY_W-1:0]            mid_rdata;
  logic                               mid_pop;
  logic                               mid_empty;
  logic [$clog2(MID_DEPTH+1)-1:0]     mid_count;
  logic                               out_push;
  logic [OUT_W:0]                     out_wdata;
  logic [OUT_W:0]                     out_rdata;
  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count;

  assign cfg = '{en: cfg_write, index: reg_index_t'(cfg_index), data: cfg_data};

  sfir_front #(
    .TAPS      (TAPS),
    .SLICE_MAX (SLICE_MAX)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .push           (push),
    .sample         (sample),
    .sample_missing (sample_missing),
    .volume_start   (volume_start),
    .full           (full),
    .mid_count      (mid_count),
    .mid_push       (mid_push),
    .mid_data       (mid_wdata)
  );

  sfir_fifo #(
    .WIDTH (TAPS * ENTRY_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count (mid_count)
  );

  sfir_back #(
    .TAPS (TAPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_data  (out_wdata)
  );

  sfir_fifo #(
    .WIDTH (OUT_W + 1),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .count (out_count)
  );

  assign filtered         = out_rdata[OUT_W-1:0];
  assign filtered_missing = out_rdata[OUT_W];

endmodule
`default_nettype wire

[rtl/sfir_fifo.sv]
// Small show-ahead queue built from registers.
`default_nettype none
module sfir_fifo import sfir_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             full;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

`ifndef SYNTHESIS
  // Credit logic upstream must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_count_bounded: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

[rtl/sfir_front.sv]
// Front end: stride and warm-up tracking, chained slice line banks, tap gather.
`default_nettype none
module sfir_front import sfir_pkg::*; #(
  parameter int TAPS      = TAPS_DEF,
  parameter int SLICE_MAX = SLICE_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire cfg_wr_t                          cfg,
  input  wire logic                             push,
  input  wire logic signed [SAMPLE_W-1:0]       sample,
  input  wire logic                             sample_missing,
  input  wire logic                             volume_start,
  output logic                                  full,
  input  wire logic [$clog2(MID_DEPTH+1)-1:0]   mid_count,
  output logic                                  mid_push,
  output logic        [TAPS*ENTRY_W-1:0]        mid_data
);

  localparam int AW = (SLICE_MAX > 1) ? $clog2(SLICE_MAX) : 1;
  localparam int LW = $clog2(SLICE_MAX + 1);
  localparam int SW = $clog2((TAPS - 1) * SLICE_MAX + 1);
  localparam int CW = $clog2(MID_DEPTH + 1);
  localparam int NB = TAPS - 1;

  logic [LW-1:0] slice_len;
  logic [SW-1:0] span;
  logic [SW-1:0] warm;
  logic [AW-1:0] ptr;

  logic [LW-1:0] len_clamp;
  logic [SW-1:0] span_new;
  logic [AW-1:0] ptr_eff;
  logic [SW-1:0] warm_eff;
  logic [LW-1:0] ptr_inc;
  logic [AW-1:0] ptr_next;
  logic [SW-1:0] warm_next;
  logic          produce;
  logic          accept;

  logic               stb_write;
  logic               stb_prod;
  logic [AW-1:0]      stb_ptr;
  logic [ENTRY_W-1:0] stb_x;

  logic [ENTRY_W-1:0] tap_rd [NB+1];

  always_comb begin
    if (cfg.data[SLICE_LEN_W-1:0] == '0) begin
      len_clamp = LW'(1);
    end else if (32'(cfg.data[SLICE_LEN_W-1:0]) > SLICE_MAX) begin
      len_clamp = LW'(SLICE_MAX);
    end else begin
      len_clamp = LW'(cfg.data[SLICE_LEN_W-1:0]);
    end
  end

  assign span_new = SW'(len_clamp) * SW'(TAPS - 1);

  assign full   = (CW + 1)'(mid_count) + (CW + 1)'(stb_prod) >= (CW + 1)'(MID_DEPTH);
  assign accept = push && !full;

  // A new volume restarts the pointer and warm-up before this beat is taken.
  assign ptr_eff   = volume_start ? '0 : ptr;
  assign warm_eff  = volume_start ? '0 : warm;
  assign produce   = (warm_eff >= span);
  assign warm_next = produce ? warm_eff : warm_eff + SW'(1);
  assign ptr_inc   = LW'(ptr_eff) + LW'(1);
  assign ptr_next  = (ptr_inc == slice_len) ? '0 : AW'(ptr_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_len <= LW'(1);
      span      <= SW'(TAPS - 1);
      warm      <= '0;
      ptr       <= '0;
      stb_write <= 1'b0;
      stb_prod  <= 1'b0;
    end else begin
      if (cfg.en && cfg.index == REG_SLICE_LENGTH) begin
        slice_len <= len_clamp;
        span      <= span_new;
        warm      <= '0;
        ptr       <= '0;
      end else if (accept) begin
        warm <= warm_next;
        ptr  <= ptr_next;
      end
      stb_write <= accept;
      stb_prod  <= accept && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stb_ptr <= ptr_eff;
      stb_x   <= {sample_missing, sample};
    end
  end

  assign tap_rd[0] = stb_x;

  // Bank k delays its input by one slice; chained, bank k holds the sample
  // k slices back at the current position within the slice.
  for (genvar k = 1; k <= NB; k++) begin : g_bank
    logic [ENTRY_W-1:0] mem [SLICE_MAX];
    logic [ENTRY_W-1:0] rd_q;
    logic               byp_q;
    logic [ENTRY_W-1:0] byp_data;
    logic               wen;
    logic [AW-1:0]      waddr;
    logic [ENTRY_W-1:0] wdata;

    if (k == 1) begin : g_head
      assign wen   = accept;
      assign waddr = ptr_eff;
      assign wdata = {sample_missing, sample};
      always_ff @(posedge clk) begin
        byp_q <= 1'b0;
      end
    end else begin : g_link
      assign wen   = stb_write;
      assign waddr = stb_ptr;
      assign wdata = tap_rd[k-1];
      // Forward a write that lands on the address read in the same cycle.
      always_ff @(posedge clk) begin
        byp_q <= stb_write && (stb_ptr == ptr_eff);
      end
    end

    always_ff @(posedge clk) begin
      if (wen) begin
        mem[waddr] <= wdata;
      end
      rd_q     <= mem[ptr_eff];
      byp_data <= wdata;
    end

    assign tap_rd[k] = byp_q ? byp_data : rd_q;
  end

  assign mid_push = stb_prod;

  for (genvar j = 0; j < TAPS; j++) begin : g_pack
    assign mid_data[j*ENTRY_W +: ENTRY_W] = tap_rd[TAPS-1-j];
  end

`ifndef SYNTHESIS
  a_ptr_in_slice: assert property (@(posedge clk) disable iff (rst)
    LW'(ptr) < slice_len)
    else $error("slice pointer beyond slice length");
  a_warm_bounded: assert property (@(posedge clk) disable iff (rst)
    warm <= span)
    else $error("warm-up count beyond span");
`endif

endmodule
`default_nettype wire

[rtl/sfir_back.sv]
// Back end: coefficient registers, multiply, two-level adder tree, result beat.
`default_nettype none
module sfir_back import sfir_pkg::*; #(
  parameter int TAPS = TAPS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cfg_wr_t                        cfg,
  input  wire logic                           mid_empty,
  input  wire logic [TAPS*ENTRY_W-1:0]        mid_data,
  output logic                                mid_pop,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                                out_push,
  output logic      [OUT_W:0]                 out_data
);

  localparam int OCW = $clog2(OUT_DEPTH + 1);
  localparam int NP  = (TAPS + 1) / 2;

  logic signed [COEF_W-1:0]   coef [TAPS];
  logic signed [SAMPLE_W-1:0] tap_val [TAPS];
  logic        [TAPS-1:0]     tap_miss;

  logic                     v1;
  logic                     v2;
  logic                     v3;
  logic signed [PROD_W-1:0] prod [TAPS];
  logic signed [OUT_W-1:0]  psum [NP];
  logic signed [OUT_W-1:0]  total;
  logic signed [OUT_W-1:0]  total_next;
  logic                     miss1;
  logic                     miss2;
  logic                     miss3;

  for (genvar j = 0; j < TAPS; j++) begin : g_unpack
    assign tap_val[j]  = mid_data[j*ENTRY_W +: SAMPLE_W];
    assign tap_miss[j] = mid_data[j*ENTRY_W + SAMPLE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < TAPS; j++) begin
        coef[j] <= '0;
      end
    end else if (cfg.en) begin
      for (int j = 0; j < TAPS; j++) begin
        if (int'(cfg.index) == j + 1) begin
          coef[j] <= cfg.data[COEF_W-1:0];
        end
      end
    end
  end

  // Hold off a pop unless every beat in flight has a slot in the result queue.
  assign mid_pop = !mid_empty &&
                   ((OCW + 2)'(out_count) + (OCW + 2)'(v1) + (OCW + 2)'(v2)
                    + (OCW + 2)'(v3) < (OCW + 2)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= mid_pop;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < TAPS; j++) begin
      prod[j] <= tap_val[j] * coef[j];
    end
    miss1 <= |tap_miss;
  end

  for (genvar i = 0; i < NP; i++) begin : g_pair
    if (2 * i + 1 < TAPS) begin : g_two
      always_ff @(posedge clk) begin
        psum[i] <= OUT_W'(prod[2*i]) + OUT_W'(prod[2*i+1]);
      end
    end else begin : g_one
      always_ff @(posedge clk) begin
        psum[i] <= OUT_W'(prod[2*i]);
      end
    end
  end

  always_comb begin
    total_next = '0;
    for (int i = 0; i < NP; i++) begin
      total_next = total_next + psum[i];
    end
  end

  always_ff @(posedge clk) begin
    miss2 <= miss1;
    miss3 <= miss2;
    total <= total_next;
  end

  // Drop the sum when any tap was missing.
  assign out_push = v3;
  assign out_data = {miss3, miss3 ? OUT_W'(0) : total};

`ifndef SYNTHESIS
  a_pop_has_room: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> (32'(out_count) + 32'(v1) + 32'(v2) + 32'(v3) < OUT_DEPTH))
    else $error("pop without result queue room");
`endif

endmodule
`default_nettype wire

[tb/sfir_watch.sv]
// Watches the FIR channels, predicts each filtered beat and compares it with the block.
module sfir_watch import sfir_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                       push,
  input  wire logic                       full,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       sample_missing,
  input  wire logic                       volume_start,
  input  wire logic                       empty,
  input  wire logic                       pop,
  input  wire logic signed [OUT_W-1:0]    filtered,
  input  wire logic                       filtered_missing,
  output int                              errors,
  output int                              pending
);
  localparam int NTAPS = TAPS_DEF;
  localparam int LINE_DEPTH = (NTAPS - 1) * SLICE_MAX_DEF;

  typedef struct packed {
    logic signed [OUT_W-1:0] sum;
    logic                    miss;
  } tap_sum_t;

  logic [SLICE_LEN_W-1:0]   slice_len;
  logic signed [COEF_W-1:0] coefs [NTAPS];
  logic signed [SAMPLE_W-1:0] line_val [LINE_DEPTH];
  logic                     line_miss [LINE_DEPTH];
  int unsigned              held;
  int unsigned              wr_pos;
  tap_sum_t                 sums_q [$];

  function automatic int unsigned tap_stride();
    if (slice_len == 0) return 1;
    if (slice_len > SLICE_MAX_DEF) return SLICE_MAX_DEF;
    return slice_len;
  endfunction

  // Store one sample in the line buffer and queue the vertical sum it completes.
  task automatic take_sample(input logic signed [SAMPLE_W-1:0] x, input logic xm,
                             input logic vs);
    int unsigned l;
    int unsigned span;
    int unsigned back;
    int unsigned pos;
    int j;
    logic signed [SAMPLE_W-1:0] v;
    logic m;
    logic signed [63:0] acc;
    tap_sum_t r;
    l = tap_stride();
    span = (NTAPS - 1) * l;
    if (vs) begin
      held = 0;
      wr_pos = 0;
    end
    if (wr_pos >= span) wr_pos = 0;
    if (held >= span) begin
      acc = 0;
      r.miss = 1'b0;
      for (j = 0; j < NTAPS; j++) begin
        back = (NTAPS - 1 - j) * l;
        if (back == 0) begin
          v = x;
          m = xm;
        end else begin
          pos = (wr_pos + span - back) % span;
          v = line_val[pos];
          m = line_miss[pos];
        end
        if (m) r.miss = 1'b1;
        else acc = acc + v * coefs[j];
      end
      r.sum = r.miss ? '0 : acc[OUT_W-1:0];
      sums_q.push_back(r);
    end
    line_val[wr_pos] = x;
    line_miss[wr_pos] = xm;
    wr_pos = (wr_pos + 1) % span;
    if (held < span) held++;
  endtask

  task automatic flag(input string field, input logic signed [63:0] want,
                      input logic signed [63:0] got);
    errors++;
    $error("%s: expected %0d, actual %0d", field, want, got);
  endtask

  always @(posedge clk) begin
    tap_sum_t r;
    if (rst) begin
      slice_len = 1;
      foreach (coefs[k]) coefs[k] = '0;
      held = 0;
      wr_pos = 0;
      sums_q.delete();
      errors = 0;
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_SLICE_LENGTH: begin
            slice_len = cfg_data[SLICE_LEN_W-1:0];
            held = 0;
            wr_pos = 0;
          end
          default: coefs[cfg_index - REG_COEF_0] = cfg_data;
        endcase
      end
      if (push && !full) take_sample(sample, sample_missing, volume_start);
      if (pop && !empty) begin
        if (sums_q.size() == 0) begin
          errors++;
          $error("beat with nothing expected: filtered %0d, filtered_missing %0b",
                 filtered, filtered_missing);
        end else begin
          r = sums_q.pop_front();
          if (filtered !== r.sum) flag("filtered", r.sum, filtered);
          if (filtered_missing !== r.miss)
            flag("filtered_missing", r.miss, filtered_missing);
        end
      end
    end
    pending = sums_q.size();
  end

endmodule

[tb/strided_fir_with_missing_marks_test.sv]
// Stimulus and verdict for the strided vertical FIR with missing-sample marks.
module strided_fir_with_missing_marks_test;
  import sfir_pkg::*;

  localparam int NTAPS = TAPS_DEF;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef logic [NTAPS-1:0][COEF_W-1:0] coef_set_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       push = 1'b0;
  logic                       full;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       sample_missing = 1'b0;
  logic                       volume_start = 1'b0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic signed [OUT_W-1:0]    filtered;
  logic                       filtered_missing;
  int                         errors;
  int                         pending;
  longint                     cycles = 0;
  int                         push_quiet = 0;
  int                         pop_quiet = 0;

  always #5 clk = ~clk;

  strided_fir_with_missing_marks i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push             (push),
    .full             (full),
    .sample           (sample),
    .sample_missing   (sample_missing),
    .volume_start     (volume_start),
    .empty            (empty),
    .pop              (pop),
    .filtered         (filtered),
    .filtered_missing (filtered_missing)
  );

  sfir_watch i_watch (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push             (push),
    .full             (full),
    .sample           (sample),
    .sample_missing   (sample_missing),
    .volume_start     (volume_start),
    .empty            (empty),
    .pop              (pop),
    .filtered         (filtered),
    .filtered_missing (filtered_missing),
    .errors           (errors),
    .pending          (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly back-to-back, some short gaps, a few long ones, now and then a quiet run.
  function automatic int draw_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r == 2) return 16'h0000;
    return 16'($urandom);
  endfunction

  // Hold push high across back-to-back beats; lower it only for a gap.
  task automatic send_beat(input logic [SAMPLE_W-1:0] s, input logic m, input logic vs);
    int gap;
    gap = draw_gap(push_quiet);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    sample <= s;
    sample_missing <= m;
    volume_start <= vs;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Write every register in one burst; stray upper bits of the length must be ignored.
  task automatic load_settings(input logic [SLICE_LEN_W-1:0] len, input coef_set_t c);
    int k;
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_SLICE_LENGTH;
    cfg_data <= {5'($urandom), len};
    for (k = 0; k < NTAPS; k++) begin
      @(posedge clk);
      cfg_index <= CFG_IDX_W'(REG_COEF_0 + k);
      cfg_data <= c[k];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait out every expected beat, then the pipeline, before touching registers.
  task automatic settle();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input logic [SLICE_LEN_W-1:0] len, input int n_items,
                           input int miss_pct, input int short_pct, input logic mark_first);
    int l;
    int span;
    int vlen;
    int done;
    int i;
    int k;
    logic first;
    coef_set_t c;
    for (k = 0; k < NTAPS; k++) c[k] = rand_word();
    load_settings(len, c);
    l = (len == 0) ? 1 : (len > SLICE_MAX_DEF) ? SLICE_MAX_DEF : len;
    span = (NTAPS - 1) * l;
    done = 0;
    first = 1'b1;
    while (done < n_items) begin
      if ($urandom_range(0, 99) < short_pct) vlen = $urandom_range(1, span);
      else vlen = span + $urandom_range(1, 2 * span + 30);
      for (i = 0; i < vlen && done < n_items; i++) begin
        send_beat(rand_word(), $urandom_range(0, 99) < miss_pct,
                  i == 0 && (!first || mark_first));
        done++;
      end
      first = 1'b0;
    end
    push <= 1'b0;
    settle();
  endtask

  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = draw_gap(pop_quiet);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  initial begin
    int i;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Zero length acts as stride one; most negative samples against the largest weights.
    load_settings(0, {NTAPS{16'h7FFF}});
    for (i = 0; i < NTAPS; i++) send_beat(16'h8000, 1'b0, i == 0);
    send_beat(16'h7FFF, 1'b0, 1'b0);
    send_beat(16'h1234, 1'b1, 1'b0);
    send_beat(16'h0001, 1'b0, 1'b0);
    push <= 1'b0;
    settle();

    // Largest positive sum; warm-up restarts on the length write, then on a volume start.
    load_settings(1, {NTAPS{16'h8000}});
    for (i = 0; i < NTAPS; i++) send_beat(16'h8000, 1'b0, 1'b0);
    send_beat(16'h0001, 1'b0, 1'b1);
    for (i = 0; i < NTAPS - 1; i++) send_beat(16'h7FFF, 1'b0, 1'b0);
    send_beat(16'hFFFF, 1'b0, 1'b0);
    push <= 1'b0;
    settle();

    run_phase(1, 200, 3, 10, 1'b1);
    run_phase(2, 150, 3, 10, 1'b0);
    run_phase(3, 150, 30, 10, 1'b1);
    run_phase(0, 120, 3, 20, 1'b1);
    run_phase(5, 150, 0, 10, 1'b1);
    run_phase(SLICE_LEN_W'($urandom_range(6, 15)), 200, 5, 10, 1'b1);
    run_phase(SLICE_LEN_W'($urandom_range(20, 60)), 400, 3, 5, 1'b0);
    run_phase(1, 150, 10, 15, 1'b1);
    // Longest strides: warm-up outlasts these beats, so no result may appear.
    run_phase(1024, 100, 2, 0, 1'b1);
    run_phase(2047, 100, 2, 0, 1'b0);

    repeat (20) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
rtl/sfir_pkg.sv
rtl/sfir_fifo.sv
rtl/sfir_front.sv
rtl/sfir_back.sv
rtl/strided_fir_with_missing_marks.sv
tb/sfir_watch.sv
tb/strided_fir_with_missing_marks_test.sv
